FILE: sv/stream_link_watchdog_backoff_core_macros.svh
// Assertion macros used by the stream link watchdog checker
`ifndef STREAM_LINK_WATCHDOG_BACKOFF_CORE_MACROS_SVH
`define STREAM_LINK_WATCHDOG_BACKOFF_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLWB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slwb assertion failed");

// next-cycle implication, disabled during reset
`define SLWB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slwb assertion failed");

`endif

FILE: sv/slwb_pkg.sv
// Types, codes and helpers for the stream link watchdog
`timescale 1ns / 1ps
package slwb_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_W     = 24;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DAT_W  = 8;
  localparam int IN_USR_W  = 3;
  localparam int OUT_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_STALL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BO  = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] STALL_RST   = CFG_W'(10000);
  localparam logic [CFG_W-1:0] CONNECT_RST = CFG_W'(10000);
  localparam logic [CFG_W-1:0] INIT_BO_RST = CFG_W'(2000);
  localparam logic [CFG_W-1:0] MAX_BO_RST  = CFG_W'(30000);

  typedef enum logic [2:0] {
    EV_TICK        = 3'd0,
    EV_LOAD        = 3'd1,
    EV_OPENED      = 3'd2,
    EV_RECONFIG    = 3'd3,
    EV_ENDED       = 3'd4,
    EV_FRAME       = 3'd5,
    EV_DRAWN       = 3'd6,
    EV_RECONN_FAIL = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    LK_CONNECTING = 4'b0001,
    LK_ONLINE     = 4'b0010,
    LK_OFFLINE    = 4'b0100,
    LK_ERROR      = 4'b1000
  } link_t;

  localparam logic [1:0] LS_CONNECTING = 2'd0;
  localparam logic [1:0] LS_ONLINE     = 2'd1;
  localparam logic [1:0] LS_OFFLINE    = 2'd2;
  localparam logic [1:0] LS_ERROR      = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_STALL   = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_RECONN  = 2'd3
  } act_t;

  typedef struct packed {
    mode_t mode;
    logic  load_failed;
    logic  end_was_error;
  } ev_t;

  typedef struct packed {
    logic [CFG_W-1:0] stall_timeout;
    logic [CFG_W-1:0] connect_timeout;
    logic [CFG_W-1:0] initial_backoff;
    logic [CFG_W-1:0] max_backoff;
  } cfg_t;

  typedef struct packed {
    act_t       tick_action;
    logic       frame_avail;
    logic       error_marker;
    logic       frame_waiting;
    logic       is_loaded;
    logic [1:0] link_state;
  } res_t;

  function automatic logic [1:0] link_code(link_t l);
    logic [1:0] c;
    case (l)
      LK_CONNECTING: c = LS_CONNECTING;
      LK_ONLINE:     c = LS_ONLINE;
      LK_OFFLINE:    c = LS_OFFLINE;
      LK_ERROR:      c = LS_ERROR;
      default:       c = LS_CONNECTING;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/slwb_core.sv
// Link state, timestamps, watchdog checks and backoff scheduling
`timescale 1ns / 1ps
module slwb_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ev_fire,
  input  slwb_pkg::ev_t  ev,
  input  slwb_pkg::cfg_t cfg,
  output slwb_pkg::res_t res
);

  typedef struct packed {
    slwb_pkg::link_t                  link;
    logic [slwb_pkg::TIME_BITS-1:0]   clk_now;
    logic [slwb_pkg::TIME_BITS-1:0]   last_frame;
    logic                             frame_armed;
    logic [slwb_pkg::TIME_BITS-1:0]   load_start;
    logic                             load_armed;
    logic [slwb_pkg::TIME_BITS-1:0]   retry;
    logic [slwb_pkg::CFG_W-1:0]       backoff;
    logic                             opened;
    logic                             pending;
    logic                             marker;
    logic                             drawn;
  } st_t;

  st_t st_r, st_nxt;
  slwb_pkg::act_t act;

  logic [slwb_pkg::TIME_BITS-1:0] clk_inc;
  logic [slwb_pkg::TIME_BITS-1:0] el_frame;
  logic [slwb_pkg::TIME_BITS-1:0] el_load;
  logic [slwb_pkg::TIME_BITS-1:0] el_retry;
  logic [slwb_pkg::TIME_BITS-1:0] sched_clk;
  logic [slwb_pkg::TIME_BITS-1:0] retry_new;
  logic [slwb_pkg::CFG_W:0]       bo_dbl;
  logic [slwb_pkg::CFG_W-1:0]     bo_new;
  logic                           stall_hit;
  logic                           tmo_hit;
  logic                           retry_due;

  assign clk_inc   = st_r.clk_now + slwb_pkg::TIME_BITS'(1);
  assign el_frame  = clk_inc - st_r.last_frame;
  assign el_load   = clk_inc - st_r.load_start;
  assign el_retry  = clk_inc - st_r.retry;
  assign sched_clk = (ev.mode == slwb_pkg::EV_TICK) ? clk_inc : st_r.clk_now;
  assign retry_new = sched_clk + slwb_pkg::TIME_BITS'(st_r.backoff);
  assign bo_dbl    = {st_r.backoff, 1'b0};
  assign bo_new    = (bo_dbl < {1'b0, cfg.max_backoff}) ? bo_dbl[slwb_pkg::CFG_W-1:0]
                                                        : cfg.max_backoff;

  assign stall_hit = (st_r.link == slwb_pkg::LK_ONLINE) && st_r.frame_armed &&
                     (slwb_pkg::CMP_W'(el_frame) >= slwb_pkg::CMP_W'(cfg.stall_timeout));
  assign tmo_hit   = (st_r.link == slwb_pkg::LK_CONNECTING) && st_r.load_armed &&
                     (slwb_pkg::CMP_W'(el_load) >= slwb_pkg::CMP_W'(cfg.connect_timeout));
  assign retry_due = ((st_r.link == slwb_pkg::LK_OFFLINE) ||
                      (st_r.link == slwb_pkg::LK_ERROR)) &&
                     !el_retry[slwb_pkg::TIME_BITS-1];

  always_comb begin
    st_nxt = st_r;
    act    = slwb_pkg::ACT_NONE;
    case (ev.mode)
      slwb_pkg::EV_TICK: begin
        st_nxt.clk_now = clk_inc;
        if (stall_hit || tmo_hit) begin
          act            = stall_hit ? slwb_pkg::ACT_STALL : slwb_pkg::ACT_TIMEOUT;
          st_nxt.opened  = 1'b0;
          st_nxt.link    = slwb_pkg::LK_ERROR;
          st_nxt.pending = 1'b0;
          st_nxt.marker  = 1'b1;
          st_nxt.retry   = retry_new;
          st_nxt.backoff = bo_new;
        end else if (retry_due) begin
          act               = slwb_pkg::ACT_RECONN;
          st_nxt.link       = slwb_pkg::LK_CONNECTING;
          st_nxt.opened     = 1'b0;
          st_nxt.pending    = 1'b0;
          st_nxt.load_start = clk_inc;
          st_nxt.load_armed = 1'b1;
        end
      end
      slwb_pkg::EV_LOAD: begin
        st_nxt.link       = slwb_pkg::LK_CONNECTING;
        st_nxt.opened     = 1'b0;
        st_nxt.pending    = 1'b0;
        st_nxt.load_start = st_r.clk_now;
        st_nxt.load_armed = 1'b1;
        if (ev.load_failed) begin
          st_nxt.link    = slwb_pkg::LK_ERROR;
          st_nxt.marker  = 1'b1;
          st_nxt.retry   = retry_new;
          st_nxt.backoff = bo_new;
        end
      end
      slwb_pkg::EV_OPENED: begin
        st_nxt.opened      = 1'b1;
        st_nxt.link        = slwb_pkg::LK_ONLINE;
        st_nxt.backoff     = cfg.initial_backoff;
        st_nxt.last_frame  = st_r.clk_now;
        st_nxt.frame_armed = 1'b1;
      end
      slwb_pkg::EV_RECONFIG: begin
        if (st_r.opened) begin
          st_nxt.link = slwb_pkg::LK_ONLINE;
        end
      end
      slwb_pkg::EV_ENDED: begin
        st_nxt.opened  = 1'b0;
        st_nxt.pending = 1'b0;
        st_nxt.marker  = 1'b1;
        st_nxt.link    = ev.end_was_error ? slwb_pkg::LK_ERROR : slwb_pkg::LK_OFFLINE;
        st_nxt.retry   = retry_new;
        st_nxt.backoff = bo_new;
      end
      slwb_pkg::EV_FRAME: begin
        st_nxt.pending     = 1'b1;
        st_nxt.last_frame  = st_r.clk_now;
        st_nxt.frame_armed = 1'b1;
      end
      slwb_pkg::EV_DRAWN: begin
        if (st_r.pending) begin
          st_nxt.pending = 1'b0;
          st_nxt.drawn   = 1'b1;
          st_nxt.marker  = 1'b0;
        end
      end
      default: begin
        st_nxt.link    = slwb_pkg::LK_ERROR;
        st_nxt.retry   = retry_new;
        st_nxt.backoff = bo_new;
      end
    endcase
  end

  assign res.link_state    = slwb_pkg::link_code(st_nxt.link);
  assign res.is_loaded     = st_nxt.opened;
  assign res.frame_waiting = st_nxt.pending;
  assign res.error_marker  = st_nxt.marker;
  assign res.frame_avail   = st_nxt.pending | st_nxt.drawn;
  assign res.tick_action   = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.link        <= slwb_pkg::LK_CONNECTING;
      st_r.clk_now     <= '0;
      st_r.last_frame  <= '0;
      st_r.frame_armed <= 1'b0;
      st_r.load_start  <= '0;
      st_r.load_armed  <= 1'b0;
      st_r.retry       <= '0;
      st_r.backoff     <= slwb_pkg::INIT_BO_RST;
      st_r.opened      <= 1'b0;
      st_r.pending     <= 1'b0;
      st_r.marker      <= 1'b0;
      st_r.drawn       <= 1'b0;
    end else if (ev_fire) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: sv/stream_link_watchdog_backoff_core.sv
// Top level of the stream link watchdog with reconnect backoff
//
//   channel | direction | handshake              | payload
//   in_     | slave     | in_tvalid / in_tready  | in_tuser mode, in_tdata flags
//   out_    | master    | out_tvalid / out_tready| out_tdata result fields
//   cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while out_tready is high; an accepted item reaches out_tvalid via the
// input register, then the result register. State updates when the input register
// hands its item to the result register. A stalled output holds one result while
// the input register takes one more item; cfg_ready is always high.
// Synchronous active-low reset restores register defaults and link state.
`timescale 1ns / 1ps
module stream_link_watchdog_backoff_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] load_failed, [1] end_was_error, [7:2] zero
  input  logic [slwb_pkg::IN_DAT_W-1:0]   in_tdata,
  // [2:0] mode
  input  logic [slwb_pkg::IN_USR_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] link_state, [2] is_loaded, [3] frame_waiting, [4] error_marker,
  // [5] frame_avail, [7:6] tick_action
  output logic [slwb_pkg::OUT_DAT_W-1:0]  out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slwb_pkg::CFG_DAT_W-1:0]  cfg_data
);

  slwb_pkg::cfg_t cfg_r;
  slwb_pkg::ev_t  stg_ev_r;
  logic           stg_valid_r;
  logic           out_valid_r;
  slwb_pkg::res_t out_res_r;
  slwb_pkg::res_t res;
  logic           stg_adv;

  assign stg_adv   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_timeout   <= slwb_pkg::STALL_RST;
      cfg_r.connect_timeout <= slwb_pkg::CONNECT_RST;
      cfg_r.initial_backoff <= slwb_pkg::INIT_BO_RST;
      cfg_r.max_backoff     <= slwb_pkg::MAX_BO_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slwb_pkg::CFG_STALL:   cfg_r.stall_timeout   <= cfg_data[slwb_pkg::CFG_W-1:0];
        slwb_pkg::CFG_CONNECT: cfg_r.connect_timeout <= cfg_data[slwb_pkg::CFG_W-1:0];
        slwb_pkg::CFG_INIT_BO: cfg_r.initial_backoff <= cfg_data[slwb_pkg::CFG_W-1:0];
        slwb_pkg::CFG_MAX_BO:  cfg_r.max_backoff     <= cfg_data[slwb_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_ev_r.mode          <= slwb_pkg::mode_t'(in_tuser);
      stg_ev_r.load_failed   <= in_tdata[0];
      stg_ev_r.end_was_error <= in_tdata[1];
    end
  end

  slwb_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev_fire (stg_adv),
    .ev      (stg_ev_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

FILE: sv/slwb_checker.sv
// Port-level checker for the stream link watchdog, bound to the top level
`timescale 1ns / 1ps
`include "stream_link_watchdog_backoff_core_macros.svh"
module slwb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [slwb_pkg::OUT_DAT_W-1:0] out_tdata
);

  slwb_pkg::res_t r;
  assign r = out_tdata;

  `SLWB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SLWB_ASSERT_IMP(a_back_press, !in_tready, out_tvalid && !out_tready)
  `SLWB_ASSERT_IMP(a_reconn, out_tvalid && (r.tick_action == slwb_pkg::ACT_RECONN),
    (r.link_state == slwb_pkg::LS_CONNECTING) && !r.is_loaded && !r.frame_waiting)
  `SLWB_ASSERT_IMP(a_fail,
    out_tvalid && ((r.tick_action == slwb_pkg::ACT_STALL) ||
                   (r.tick_action == slwb_pkg::ACT_TIMEOUT)),
    (r.link_state == slwb_pkg::LS_ERROR) && r.error_marker && !r.is_loaded)
  `SLWB_ASSERT_IMP(a_ready, out_tvalid && r.frame_waiting, r.frame_avail)

endmodule

bind stream_link_watchdog_backoff_core slwb_checker u_slwb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
